>>> rtl/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define CHK_HOLDS(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define CHK_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rtscu_pkg.sv
package rtscu_pkg;

   localparam int KEY_W          = 22;
   localparam int CNT_W          = 8;
   localparam int CODE_W         = 16;
   localparam int ATTR_W         = 2;
   localparam int TILE_W         = 10;
   localparam int SLOT_IDX_OUT_W = 8;
   localparam int TILE_BASE      = 256;
   localparam int SLOT_COUNT_DEF = 256;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      OP_LOOKUP  = 2'd0,
      OP_ACQUIRE = 2'd1,
      OP_RELEASE = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   // search token walking the cell row
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic             free;
      logic [CNT_W-1:0] hit_cnt;
   } tok_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic             search;
      logic             incr;
      logic             drop;
      logic             alloc;
      logic             clear_all;
      logic [KEY_W-1:0] key;
   } cmd_type;

endpackage

>>> rtl/rtscu_cell.sv
module rtscu_cell #(
   parameter int IDX_W      = 8,
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rtscu_pkg::cmd_type   cmd,
   input  logic [IDX_W-1:0]     wr_idx,
   input  rtscu_pkg::tok_type   tok_in,
   input  logic [IDX_W-1:0]     hit_idx_in,
   input  logic [IDX_W-1:0]     free_idx_in,
   output rtscu_pkg::tok_type   tok_out,
   output logic [IDX_W-1:0]     hit_idx_out,
   output logic [IDX_W-1:0]     free_idx_out
);
   import rtscu_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_bump;
   tok_type          tok_ff, tok_in_d;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in_d;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in_d;
   logic             in_use, match, drop_here, take, addressed;

   assign in_use    = (cnt_ff != '0);
   assign addressed = (wr_idx == MY_IDX);
   assign match     = cmd.search && in_use && (key_ff == cmd.key);
   assign drop_here = cmd.drop && addressed && in_use;
   assign take      = tok_in.valid && !tok_in.hit && (match || drop_here);

   always_comb begin
      if (drop_here) begin
         cnt_bump = cnt_ff - CNT_W'(1);
      end else if (cmd.incr && (cnt_ff != CNT_MAX)) begin
         cnt_bump = cnt_ff + CNT_W'(1);
      end else begin
         cnt_bump = cnt_ff;
      end
   end

   always_comb begin
      tok_in_d      = tok_in;
      hit_idx_in_d  = hit_idx_in;
      free_idx_in_d = free_idx_in;
      if (take) begin
         tok_in_d.hit     = 1'b1;
         tok_in_d.hit_cnt = cnt_bump;
         hit_idx_in_d     = MY_IDX;
      end
      if (tok_in.valid && !tok_in.free && !in_use) begin
         tok_in_d.free = 1'b1;
         free_idx_in_d = MY_IDX;
      end
   end

   always_comb begin
      key_in = key_ff;
      cnt_in = cnt_ff;
      if (take) begin
         cnt_in = cnt_bump;
      end
      if (cmd.alloc && addressed) begin
         key_in = cmd.key;
         cnt_in = CNT_W'(1);
      end
      if (cmd.clear_all) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         tok_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         tok_ff <= tok_in_d;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      hit_idx_ff  <= hit_idx_in_d;
      free_idx_ff <= free_idx_in_d;
   end

   assign tok_out      = tok_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;

endmodule

>>> rtl/refcounted_tile_slot_cache_unit.sv
// lookup, acquire and release send a search token that steps through the row of slot cells
//   one cell per cycle; the result then passes to the output register. clear needs no sweep
// one item at a time: a new request is stalled until the previous result has reached the output register
// stalls: a finished result waits while the output register holds a stalled beat
// reset: synchronous, active high; every slot is freed at once, no clearing pass
module refcounted_tile_slot_cache_unit #(
   parameter int SLOT_COUNT = rtscu_pkg::SLOT_COUNT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_op,
   input  logic [rtscu_pkg::CODE_W-1:0]           req_char_code,
   input  logic [rtscu_pkg::ATTR_W-1:0]           req_attr_a,
   input  logic [rtscu_pkg::ATTR_W-1:0]           req_attr_b,
   input  logic [rtscu_pkg::ATTR_W-1:0]           req_attr_c,
   input  logic [rtscu_pkg::TILE_W-1:0]           req_tile_number,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_success,
   output logic [rtscu_pkg::SLOT_IDX_OUT_W-1:0]   rsp_slot_index,
   output logic                                   rsp_newly_allocated,
   output logic [rtscu_pkg::CNT_W-1:0]            rsp_count_after
);
   import rtscu_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [TILE_W:0] SLOT_LIM = (TILE_W+1)'(SLOT_COUNT);
   localparam logic [TILE_W-1:0] TILE_BASE_V = TILE_W'(TILE_BASE);

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SWEEP  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // item held for the whole sweep
   op_type             op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic               rel_ok_ff, rel_ok_in;

   // one-cycle pulses into the cell row
   logic start_ff, start_in;
   logic clear_ff, clear_in;
   logic alloc_ff, alloc_in;

   // finished result waiting for the output register
   logic                      res_success_ff, res_success_in;
   logic [SLOT_IDX_OUT_W-1:0] res_idx_ff, res_idx_in;
   logic                      res_new_ff, res_new_in;
   logic [CNT_W-1:0]          res_cnt_ff, res_cnt_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_success_ff, rsp_success_in;
   logic [SLOT_IDX_OUT_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                      rsp_new_ff, rsp_new_in;
   logic [CNT_W-1:0]          rsp_cnt_ff, rsp_cnt_in;

   logic               req_accept;
   logic [TILE_W-1:0]  tile_diff;
   logic               rel_ok;
   cmd_type            cmd;

   // token chain: entry g feeds cell g, entry SLOT_COUNT is the row's tail
   tok_type            tok_chain      [SLOT_COUNT+1];
   logic [IDX_W-1:0]   hit_idx_chain  [SLOT_COUNT+1];
   logic [IDX_W-1:0]   free_idx_chain [SLOT_COUNT+1];
   tok_type            tok_end;
   logic [IDX_W-1:0]   hit_idx_end;
   logic [IDX_W-1:0]   free_idx_end;

   // one item at a time; the output register decouples the response side
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // release target: tile number minus the tile base, checked against the table size
   assign tile_diff = req_tile_number - TILE_BASE_V;
   assign rel_ok    = (req_tile_number >= TILE_BASE_V) && ({1'b0, tile_diff} < SLOT_LIM);

   // broadcast to the cells
   always_comb begin
      cmd.search    = (op_ff == OP_LOOKUP) || (op_ff == OP_ACQUIRE);
      cmd.incr      = (op_ff == OP_ACQUIRE);
      cmd.drop      = (op_ff == OP_RELEASE) && rel_ok_ff;
      cmd.alloc     = alloc_ff;
      cmd.clear_all = clear_ff;
      cmd.key       = key_ff;
   end

   // head of the row: a fresh token with nothing found yet
   always_comb begin
      tok_chain[0]         = '0;
      tok_chain[0].valid   = start_ff;
      hit_idx_chain[0]     = '0;
      free_idx_chain[0]    = '0;
   end

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      rtscu_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .wr_idx       (wr_idx_ff),
         .tok_in       (tok_chain[g]),
         .hit_idx_in   (hit_idx_chain[g]),
         .free_idx_in  (free_idx_chain[g]),
         .tok_out      (tok_chain[g+1]),
         .hit_idx_out  (hit_idx_chain[g+1]),
         .free_idx_out (free_idx_chain[g+1])
      );
   end

   assign tok_end      = tok_chain[SLOT_COUNT];
   assign hit_idx_end  = hit_idx_chain[SLOT_COUNT];
   assign free_idx_end = free_idx_chain[SLOT_COUNT];

   // sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      wr_idx_in      = wr_idx_ff;
      rel_ok_in      = rel_ok_ff;
      start_in       = 1'b0;
      clear_in       = 1'b0;
      alloc_in       = 1'b0;
      res_success_in = res_success_ff;
      res_idx_in     = res_idx_ff;
      res_new_in     = res_new_ff;
      res_cnt_in     = res_cnt_ff;
      // a taken beat leaves the output register
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_success_in = rsp_success_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_new_in     = rsp_new_ff;
      rsp_cnt_in     = rsp_cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = op_type'(req_op);
               key_in    = {req_attr_c, req_attr_b, req_attr_a, req_char_code};
               wr_idx_in = tile_diff[IDX_W-1:0];
               rel_ok_in = rel_ok;
               if (op_type'(req_op) == OP_CLEAR) begin
                  // the clear pulse is registered, then the cells drop every count
                  clear_in       = 1'b1;
                  res_success_in = 1'b1;
                  res_idx_in     = '0;
                  res_new_in     = 1'b0;
                  res_cnt_in     = '0;
                  state_in       = ST_FINISH;
               end else begin
                  start_in = 1'b1;
                  state_in = ST_SWEEP;
               end
            end
         end

         ST_SWEEP: begin
            if (tok_end.valid) begin
               res_success_in = 1'b0;
               res_idx_in     = '0;
               res_new_in     = 1'b0;
               res_cnt_in     = '0;
               if (tok_end.hit) begin
                  // lookup hit, acquire hit (count already bumped unless saturated) or release done
                  res_success_in = 1'b1;
                  res_idx_in     = SLOT_IDX_OUT_W'(hit_idx_end);
                  res_cnt_in     = tok_end.hit_cnt;
               end else if ((op_ff == OP_ACQUIRE) && tok_end.free) begin
                  // no match: claim the lowest free slot
                  alloc_in       = 1'b1;
                  wr_idx_in      = free_idx_end;
                  res_success_in = 1'b1;
                  res_idx_in     = SLOT_IDX_OUT_W'(free_idx_end);
                  res_new_in     = 1'b1;
                  res_cnt_in     = CNT_W'(1);
               end
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = res_success_ff;
               rsp_idx_in     = res_idx_ff;
               rsp_new_in     = res_new_ff;
               rsp_cnt_in     = res_cnt_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         clear_ff     <= 1'b0;
         alloc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         clear_ff     <= clear_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      wr_idx_ff      <= wr_idx_in;
      rel_ok_ff      <= rel_ok_in;
      res_success_ff <= res_success_in;
      res_idx_ff     <= res_idx_in;
      res_new_ff     <= res_new_in;
      res_cnt_ff     <= res_cnt_in;
      rsp_success_ff <= rsp_success_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_new_ff     <= rsp_new_in;
      rsp_cnt_ff     <= rsp_cnt_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_success         = rsp_success_ff;
   assign rsp_slot_index      = rsp_idx_ff;
   assign rsp_newly_allocated = rsp_new_ff;
   assign rsp_count_after     = rsp_cnt_ff;

endmodule

>>> rtl/rtscu_checker.sv
`include "assert_macros.svh"

module rtscu_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_success,
   input logic [rtscu_pkg::SLOT_IDX_OUT_W-1:0] rsp_slot_index,
   input logic                                 rsp_newly_allocated,
   input logic [rtscu_pkg::CNT_W-1:0]          rsp_count_after
);
   import rtscu_pkg::*;

   // a stalled beat keeps its slot index
   `CHK_HOLDS(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot_index), "stalled response beat changed")

   // a failed operation reports nothing else
   `CHK_HOLDS(a_fail_zero, clock, reset, rsp_valid && !rsp_success |-> rsp_slot_index == '0 && rsp_count_after == '0 && !rsp_newly_allocated, "failed beat carries nonzero fields")

   // a fresh claim always starts at a count of one
   `CHK_HOLDS(a_alloc_one, clock, reset, rsp_valid && rsp_newly_allocated |-> rsp_success && rsp_count_after == CNT_W'(1), "new slot without count of one")

   // reset leaves no response pending
   `CHK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind refcounted_tile_slot_cache_unit rtscu_checker u_rtscu_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_success         (rsp_success),
   .rsp_slot_index      (rsp_slot_index),
   .rsp_newly_allocated (rsp_newly_allocated),
   .rsp_count_after     (rsp_count_after)
);
